[design/agkf_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and the saturation helper of the angle/gyro Kalman filter.
package agkf_pkg;

	localparam int DATA_WIDTH_DEF = 32;

	// operand and result widths of the shared units
	localparam int COEF_W = 32;
	localparam int PDOT_W = 34;
	localparam int DEN_W  = 37;
	localparam int RES_W  = 64;

	localparam int DT_SHIFT   = 24;
	localparam int GAIN_SHIFT = 28;

	localparam logic [23:0] TIME_STEP_RST   = 24'd83886;
	localparam logic [23:0] ANGLE_NOISE_RST = 24'd33554;
	localparam logic [23:0] BIAS_NOISE_RST  = 24'd33554;
	localparam logic [31:0] MEAS_NOISE_RST  = 32'd8388608;

	localparam logic signed [COEF_W-1:0] COV_ONE = 32'sh1000_0000;

	// products are clamped to 2^62 in magnitude
	localparam logic [62:0] PROD_LIMIT = 63'h4000_0000_0000_0000;

	typedef enum logic [1:0] {
		REG_TIME_STEP,
		REG_ANGLE_NOISE,
		REG_BIAS_NOISE,
		REG_MEAS_NOISE
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic gain_scale;
	} mul_ctl_t;

	function automatic logic signed [RES_W-1:0] sat_to(input logic signed [RES_W-1:0] v,
		input int w);
		logic signed [RES_W-1:0] lim;
		lim = $signed(64'd1 << (w - 1));
		if (v > lim - 1) begin
			sat_to = lim - 1;
		end else if (v < -lim) begin
			sat_to = -lim;
		end else begin
			sat_to = v;
		end
	endfunction

endpackage

[design/angle_gyro_kalman_filter_unit.sv]
`timescale 1ns / 1ps
// Two-state Kalman filter (angle and gyro bias) fusing an accelerometer angle with a gyro rate.
// Input stream s_*: one item holds a measured angle and a raw gyro rate (Q16.16).
// Output stream m_*: one item per input, filtered angle and bias-corrected rate (Q16.16).
// APB port: time step, angle and bias process noise, measurement noise; write only while idle.
// Each item runs through a small sequencer that drives one shared multiplier (10 products)
// and one restoring divider (2 gains). A new item is taken only once the result of the
// last one has gone into the output register, so items do not overlap. When the innovation
// variance is not positive the correction is skipped.
// s_tready is high only while the sequencer is idle. A finished result waits in the output
// register while m_tready is low; the next item may still be accepted and is held in its
// final step until the output register frees up.
// Reset restores the register defaults, zeroes the angle and bias estimates and sets the
// covariance to the identity.
module angle_gyro_kalman_filter_unit #(
	parameter int DATA_WIDTH = agkf_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] measured_angle, [63:32] measured_rate
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [31:0] filtered_angle, [63:32] corrected_rate
);
	import agkf_pkg::*;

	localparam int A_W = (DATA_WIDTH > PDOT_W) ? DATA_WIDTH : PDOT_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RATE, ST_LAUNCH, ST_WAIT, ST_INNOV, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		STP_ANG_PRED, STP_P00_PRED, STP_P01_PRED, STP_P11_PRED,
		STP_K0, STP_K1,
		STP_P10_CORR, STP_P11_CORR, STP_P01_CORR, STP_P00_CORR,
		STP_ANG_CORR, STP_BIAS_CORR
	} step_t;

	// configuration
	logic [23:0] dt_q;
	logic [23:0] qa_q;
	logic [23:0] qb_q;
	logic [31:0] r_q;

	// filter state
	state_t                    state_q;
	step_t                     step_q;
	logic signed [DATA_WIDTH-1:0] ang_q;
	logic signed [DATA_WIDTH-1:0] bias_q;
	logic signed [DATA_WIDTH-1:0] rate_q;
	logic signed [DATA_WIDTH-1:0] err_q;
	logic signed [COEF_W-1:0]  p00_q;
	logic signed [COEF_W-1:0]  p01_q;
	logic signed [COEF_W-1:0]  p10_q;
	logic signed [COEF_W-1:0]  p11_q;
	logic signed [COEF_W-1:0]  k0_q;
	logic signed [COEF_W-1:0]  k1_q;
	logic signed [31:0]        m_angle_q;
	logic signed [31:0]        m_rate_q;
	logic [DEN_W-1:0]          den_q;
	logic                      out_valid_q;
	logic [63:0]               out_data_q;

	// shared units
	mul_ctl_t                  mul_ctl;
	logic signed [A_W-1:0]     mul_a;
	logic signed [COEF_W-1:0]  mul_b;
	logic                      mul_done;
	logic signed [RES_W-1:0]   mul_res;
	logic                      div_start;
	logic signed [COEF_W-1:0]  div_num;
	logic                      div_done;
	logic signed [COEF_W-1:0]  div_gain;

	logic signed [PDOT_W-1:0]  pdot0;
	logic signed [RES_W-1:0]   dst;
	logic                      dst_sub;
	int                        dst_w;
	logic signed [RES_W-1:0]   upd;
	logic signed [RES_W-1:0]   p10_pred;
	logic signed [RES_W-1:0]   rate_new;
	logic signed [RES_W-1:0]   err_new;
	logic signed [RES_W-1:0]   filt_out;
	logic signed [RES_W-1:0]   corr_out;
	logic signed [DEN_W:0]     innov;
	logic                      innov_pos;
	logic                      is_div_step;
	logic                      cfg_wr;
	logic                      out_load;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= TIME_STEP_RST;
			qa_q <= ANGLE_NOISE_RST;
			qb_q <= BIAS_NOISE_RST;
			r_q  <= MEAS_NOISE_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_TIME_STEP:   dt_q <= pwdata[23:0];
				REG_ANGLE_NOISE: qa_q <= pwdata[23:0];
				REG_BIAS_NOISE:  qb_q <= pwdata[23:0];
				REG_MEAS_NOISE:  r_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_TIME_STEP:   prdata = {8'd0, dt_q};
			REG_ANGLE_NOISE: prdata = {8'd0, qa_q};
			REG_BIAS_NOISE:  prdata = {8'd0, qb_q};
			REG_MEAS_NOISE:  prdata = r_q;
			default:         prdata = '0;
		endcase
	end

	// ---------------- operand selection ----------------
	always_comb begin
		pdot0 = $signed({6'd0, qa_q, 4'd0}) - PDOT_W'(p01_q) - PDOT_W'(p10_q);
		is_div_step = (step_q == STP_K0) || (step_q == STP_K1);

		mul_a = '0;
		mul_b = $signed({8'd0, dt_q});
		mul_ctl.gain_scale = 1'b0;
		case (step_q)
			STP_ANG_PRED: mul_a = A_W'(rate_q);
			STP_P00_PRED: mul_a = A_W'(pdot0);
			STP_P01_PRED: mul_a = A_W'(p11_q);
			STP_P11_PRED: mul_a = A_W'($signed({1'b0, qb_q, 4'd0}));
			STP_P10_CORR: begin
				mul_a = A_W'(p00_q);
				mul_b = k1_q;
				mul_ctl.gain_scale = 1'b1;
			end
			STP_P11_CORR: begin
				mul_a = A_W'(p01_q);
				mul_b = k1_q;
				mul_ctl.gain_scale = 1'b1;
			end
			STP_P01_CORR: begin
				mul_a = A_W'(p01_q);
				mul_b = k0_q;
				mul_ctl.gain_scale = 1'b1;
			end
			STP_P00_CORR: begin
				mul_a = A_W'(p00_q);
				mul_b = k0_q;
				mul_ctl.gain_scale = 1'b1;
			end
			STP_ANG_CORR: begin
				mul_a = A_W'(err_q);
				mul_b = k0_q;
				mul_ctl.gain_scale = 1'b1;
			end
			STP_BIAS_CORR: begin
				mul_a = A_W'(err_q);
				mul_b = k1_q;
				mul_ctl.gain_scale = 1'b1;
			end
			default: ;
		endcase
		mul_ctl.start = (state_q == ST_LAUNCH) && !is_div_step;
		div_start     = (state_q == ST_LAUNCH) && is_div_step;
		div_num       = (step_q == STP_K1) ? p10_q : p00_q;
	end

	// ---------------- state update arithmetic ----------------
	always_comb begin
		dst     = '0;
		dst_sub = 1'b1;
		dst_w   = COEF_W;
		case (step_q)
			STP_ANG_PRED: begin
				dst     = RES_W'(ang_q);
				dst_sub = 1'b0;
				dst_w   = DATA_WIDTH;
			end
			STP_P00_PRED: begin
				dst     = RES_W'(p00_q);
				dst_sub = 1'b0;
			end
			STP_P01_PRED: dst = RES_W'(p01_q);
			STP_P11_PRED: begin
				dst     = RES_W'(p11_q);
				dst_sub = 1'b0;
			end
			STP_P10_CORR: dst = RES_W'(p10_q);
			STP_P11_CORR: dst = RES_W'(p11_q);
			STP_P01_CORR: dst = RES_W'(p01_q);
			STP_P00_CORR: dst = RES_W'(p00_q);
			STP_ANG_CORR: begin
				dst     = RES_W'(ang_q);
				dst_sub = 1'b0;
				dst_w   = DATA_WIDTH;
			end
			STP_BIAS_CORR: begin
				dst     = RES_W'(bias_q);
				dst_sub = 1'b0;
				dst_w   = DATA_WIDTH;
			end
			default: ;
		endcase
		upd      = sat_to(dst_sub ? dst - mul_res : dst + mul_res, dst_w);
		p10_pred = sat_to(RES_W'(p10_q) - mul_res, COEF_W);

		rate_new = sat_to(RES_W'(m_rate_q) - RES_W'(bias_q), DATA_WIDTH);
		err_new  = sat_to(RES_W'(m_angle_q) - RES_W'(ang_q), DATA_WIDTH);
		filt_out = sat_to(RES_W'(ang_q), 32);
		corr_out = sat_to(RES_W'(m_rate_q) - RES_W'(bias_q), 32);

		innov     = $signed({2'd0, r_q, 4'd0}) + (DEN_W+1)'(p00_q);
		innov_pos = !innov[DEN_W] && (innov != '0);
	end

	// ---------------- sequencer ----------------
	assign s_tready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STP_ANG_PRED;
			ang_q       <= '0;
			bias_q      <= '0;
			p00_q       <= COV_ONE;
			p01_q       <= '0;
			p10_q       <= '0;
			p11_q       <= COV_ONE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						m_angle_q <= $signed(s_tdata[31:0]);
						m_rate_q  <= $signed(s_tdata[63:32]);
						state_q   <= ST_RATE;
					end
				end
				ST_RATE: begin
					rate_q  <= rate_new[DATA_WIDTH-1:0];
					step_q  <= STP_ANG_PRED;
					state_q <= ST_LAUNCH;
				end
				ST_LAUNCH: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (mul_done || div_done) begin
						state_q <= ST_LAUNCH;
						case (step_q)
							STP_ANG_PRED: begin
								ang_q  <= upd[DATA_WIDTH-1:0];
								step_q <= STP_P00_PRED;
							end
							STP_P00_PRED: begin
								p00_q  <= upd[COEF_W-1:0];
								step_q <= STP_P01_PRED;
							end
							STP_P01_PRED: begin
								p01_q  <= upd[COEF_W-1:0];
								p10_q  <= p10_pred[COEF_W-1:0];
								step_q <= STP_P11_PRED;
							end
							STP_P11_PRED: begin
								p11_q   <= upd[COEF_W-1:0];
								state_q <= ST_INNOV;
							end
							STP_K0: begin
								k0_q   <= div_gain;
								step_q <= STP_K1;
							end
							STP_K1: begin
								k1_q   <= div_gain;
								step_q <= STP_P10_CORR;
							end
							STP_P10_CORR: begin
								p10_q  <= upd[COEF_W-1:0];
								step_q <= STP_P11_CORR;
							end
							STP_P11_CORR: begin
								p11_q  <= upd[COEF_W-1:0];
								step_q <= STP_P01_CORR;
							end
							STP_P01_CORR: begin
								p01_q  <= upd[COEF_W-1:0];
								step_q <= STP_P00_CORR;
							end
							STP_P00_CORR: begin
								p00_q  <= upd[COEF_W-1:0];
								step_q <= STP_ANG_CORR;
							end
							STP_ANG_CORR: begin
								ang_q  <= upd[DATA_WIDTH-1:0];
								step_q <= STP_BIAS_CORR;
							end
							STP_BIAS_CORR: begin
								bias_q  <= upd[DATA_WIDTH-1:0];
								state_q <= ST_OUT;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_INNOV: begin
					err_q <= err_new[DATA_WIDTH-1:0];
					den_q <= innov[DEN_W-1:0];
					// skip the correction when the innovation variance is not positive
					if (innov_pos) begin
						step_q  <= STP_K0;
						state_q <= ST_LAUNCH;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_data_q  <= {corr_out[31:0], filt_out[31:0]};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	agkf_mul #(
		.A_W (A_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	agkf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_q),
		.done   (div_done),
		.gain   (div_gain)
	);

endmodule

[design/agkf_mul.sv]
`timescale 1ns / 1ps
// Shared sign-magnitude multiplier with round-to-nearest scaling and clamp, two partial products.
module agkf_mul #(
	parameter int A_W = 34
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  agkf_pkg::mul_ctl_t                    ctl,
	input  logic signed [A_W-1:0]                 a,
	input  logic signed [agkf_pkg::COEF_W-1:0]    b,
	output logic                                  done,
	output logic signed [agkf_pkg::RES_W-1:0]     res
);
	import agkf_pkg::*;

	localparam int HALF = (A_W + 1) / 2;
	localparam int HI_W = A_W - HALF;
	localparam int PW   = A_W + COEF_W;

	typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_RND} mstate_t;

	mstate_t                   state_q;
	logic [A_W-1:0]            a_mag_q;
	logic [COEF_W-1:0]         b_mag_q;
	logic                      neg_q;
	logic                      gain_q;
	logic [PW-1:0]             acc_q;
	logic                      done_q;
	logic signed [RES_W-1:0]   res_q;

	logic [HALF+COEF_W-1:0]    lo_raw;
	logic [HI_W+COEF_W-1:0]    hi_raw;
	logic [PW-1:0]             lo_prod;
	logic [PW-1:0]             hi_prod;
	logic [PW:0]               half;
	logic [PW:0]               rnd;
	logic [PW:0]               shifted;
	logic [62:0]               r_mag;

	always_comb begin
		lo_raw  = a_mag_q[HALF-1:0] * b_mag_q;
		hi_raw  = a_mag_q[A_W-1:HALF] * b_mag_q;
		lo_prod = PW'(lo_raw);
		hi_prod = PW'(hi_raw) << HALF;
		half    = gain_q ? (PW+1)'(1 << (GAIN_SHIFT - 1)) : (PW+1)'(1 << (DT_SHIFT - 1));
		rnd     = {1'b0, acc_q} + half;
		shifted = gain_q ? (rnd >> GAIN_SHIFT) : (rnd >> DT_SHIFT);
		r_mag   = (shifted > (PW+1)'(PROD_LIMIT)) ? PROD_LIMIT : shifted[62:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (ctl.start) begin
						a_mag_q <= a[A_W-1] ? $unsigned(-a) : $unsigned(a);
						b_mag_q <= b[COEF_W-1] ? $unsigned(-b) : $unsigned(b);
						neg_q   <= a[A_W-1] ^ b[COEF_W-1];
						gain_q  <= ctl.gain_scale;
						state_q <= M_LO;
					end
				end
				M_LO: begin
					acc_q   <= lo_prod;
					state_q <= M_HI;
				end
				M_HI: begin
					acc_q   <= acc_q + hi_prod;
					state_q <= M_RND;
				end
				M_RND: begin
					res_q   <= neg_q ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[design/agkf_div.sv]
`timescale 1ns / 1ps
// Restoring divider for the Kalman gain: (|num| << 28) / den, one quotient bit per cycle.
module agkf_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [agkf_pkg::COEF_W-1:0]   num,
	input  logic [agkf_pkg::DEN_W-1:0]           den,
	output logic                                 done,
	output logic signed [agkf_pkg::COEF_W-1:0]   gain
);
	import agkf_pkg::*;

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

	dstate_t                   state_q;
	logic [4:0]                cnt_q;
	logic [DEN_W-1:0]          rem_q;
	logic [DEN_W-1:0]          den_q;
	logic [COEF_W-1:0]         n_q;
	logic [COEF_W-1:0]         q_q;
	logic                      ovf_q;
	logic                      neg_q;
	logic                      done_q;
	logic signed [COEF_W-1:0]  gain_q;

	logic [COEF_W-1:0]         mag;
	logic [DEN_W:0]            trial;
	logic [DEN_W:0]            diff;
	logic                      ge;

	always_comb begin
		mag   = num[COEF_W-1] ? $unsigned(-num) : $unsigned(num);
		trial = {rem_q, n_q[COEF_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						// quotient of 2^32 or more saturates regardless
						ovf_q   <= DEN_W'(mag[COEF_W-1:4]) >= den;
						rem_q   <= DEN_W'(mag[COEF_W-1:4]);
						n_q     <= {mag[3:0], 28'd0};
						q_q     <= '0;
						den_q   <= den;
						neg_q   <= num[COEF_W-1];
						cnt_q   <= 5'd31;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
					q_q   <= {q_q[COEF_W-2:0], ge};
					n_q   <= n_q << 1;
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					if (!neg_q) begin
						gain_q <= (ovf_q || q_q[COEF_W-1]) ? 32'sh7fff_ffff : $signed(q_q);
					end else begin
						gain_q <= (ovf_q || q_q > 32'h8000_0000) ? 32'sh8000_0000
							: -$signed(q_q);
					end
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign gain = gain_q;

endmodule
